@@ rtl/core/bpsl_pkg.sv @@
package bpsl_pkg;

    // Item opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_LINK = 2'd1;
    localparam logic [1:0] OP_ATOM = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Link states
    localparam logic [1:0] LINK_PAIRING = 2'd0;
    localparam logic [1:0] LINK_NO_ADDR = 2'd1;
    localparam logic [1:0] LINK_GOT_ADDR = 2'd2;
    localparam logic [1:0] LINK_IDLE = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_DIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOT_IP_HOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REBOOT_DELAY = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_SHORT_LIMIT = 16'd75;
    localparam logic [15:0] RST_LONG_LIMIT = 16'd125;
    localparam logic [7:0] RST_BLINK_DIV = 8'd12;
    localparam logic [7:0] RST_GOT_IP_HOLD = 8'd150;
    localparam logic [5:0] RST_REBOOT_DELAY = 6'd20;

    // Counter ceilings
    localparam logic [15:0] PRESS_MAX = 16'hFFFF;
    localparam logic [6:0] REBOOT_MAX = 7'd127;

    typedef struct packed {
        logic [1:0] op;
        logic       key_level;
        logic [1:0] link_value;
        logic       enable;
    } item_t;

    typedef struct packed {
        logic       red_led;
        logic       atomizer_on;
        logic       power_on;
        logic       short_press;
        logic       erase_request;
        logic       reboot_request;
        logic [1:0] link_now;
    } result_t;

    typedef struct packed {
        logic [15:0] short_press_limit;
        logic [15:0] long_press_limit;
        logic [7:0]  blink_divide;
        logic [7:0]  got_ip_hold;
        logic [5:0]  reboot_delay;
    } cfg_t;

    // Handshake between the input register and the result register
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

@@ rtl/core/bpsl_cfg.sv @@
module bpsl_cfg
    import bpsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Register file, write only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_press_limit <= RST_SHORT_LIMIT;
            cfg_reg.long_press_limit <= RST_LONG_LIMIT;
            cfg_reg.blink_divide <= RST_BLINK_DIV;
            cfg_reg.got_ip_hold <= RST_GOT_IP_HOLD;
            cfg_reg.reboot_delay <= RST_REBOOT_DELAY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SHORT_LIMIT:  cfg_reg.short_press_limit <= cfg_data;
                CFG_LONG_LIMIT:   cfg_reg.long_press_limit <= cfg_data;
                CFG_BLINK_DIV:    cfg_reg.blink_divide <= cfg_data[7:0];
                CFG_GOT_IP_HOLD:  cfg_reg.got_ip_hold <= cfg_data[7:0];
                CFG_REBOOT_DELAY: cfg_reg.reboot_delay <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/bpsl_in_stage.sv @@
module bpsl_in_stage
    import bpsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    input  logic       out_free,
    output stage_ctl_t ctl,
    output item_t      held
);

    logic  valid_reg;
    logic  valid_next;
    item_t data_reg;
    logic  advance;
    logic  take;

    // Beat leaves when the result register can take it
    assign advance = valid_reg && out_free;
    assign item_stall = valid_reg && !out_free;
    assign take = item_valid && !item_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= item;
    end

    assign ctl.valid = valid_reg;
    assign ctl.advance = advance;
    assign held = data_reg;

endmodule

@@ rtl/core/bpsl_engine.sv @@
module bpsl_engine
    import bpsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  stage_ctl_t ctl,
    input  item_t      held,
    output result_t    res
);

    logic [1:0]  link_reg,    link_next;
    logic [7:0]  blink_reg,   blink_next;
    logic [8:0]  hold_reg,    hold_next;
    logic [15:0] press_reg,   press_next;
    logic [6:0]  reboot_reg,  reboot_next;
    logic        red_reg,     red_next;
    logic        power_reg,   power_next;
    logic        atom_reg,    atom_next;
    logic        phase_reg,   phase_next;
    logic        fired_reg,   fired_next;
    logic        sp, er;
    logic [7:0]  blink_inc;

    assign blink_inc = blink_reg + 8'd1;

    // Next state for the beat in the input register
    always_comb
    begin
        link_next = link_reg;
        blink_next = blink_reg;
        hold_next = hold_reg;
        press_next = press_reg;
        reboot_next = reboot_reg;
        red_next = red_reg;
        power_next = power_reg;
        atom_next = atom_reg;
        phase_next = phase_reg;
        fired_next = fired_reg;
        sp = 1'b0;
        er = 1'b0;

        case (held.op)
            OP_TICK:
            begin
                // LED pattern
                unique case (link_reg)
                    LINK_PAIRING:
                    begin
                        blink_next = blink_inc;
                        if (blink_inc >= cfg.blink_divide)
                        begin
                            blink_next = '0;
                            phase_next = !phase_reg;
                            red_next = !phase_reg;
                        end
                    end
                    LINK_NO_ADDR:
                        red_next = 1'b0;
                    LINK_GOT_ADDR:
                    begin
                        if (hold_reg == '0)
                        begin
                            red_next = 1'b1;
                            hold_next = 9'd1;
                        end
                        else if (hold_reg > {1'b0, cfg.got_ip_hold})
                        begin
                            hold_next = '0;
                            red_next = 1'b0;
                            link_next = LINK_IDLE;
                        end
                        else
                            hold_next = hold_reg + 9'd1;
                    end
                    default: ;
                endcase

                // Button; ignored once the reboot countdown runs
                if (reboot_reg != '0)
                begin
                    if (reboot_reg < REBOOT_MAX)
                        reboot_next = reboot_reg + 7'd1;
                    if (reboot_next > {1'b0, cfg.reboot_delay})
                        fired_next = 1'b1;
                end
                else if (!held.key_level)
                begin
                    if (press_reg < PRESS_MAX)
                        press_next = press_reg + 16'd1;
                end
                else
                begin
                    if (press_reg != '0)
                    begin
                        if (press_reg < cfg.short_press_limit)
                        begin
                            power_next = !power_reg;
                            atom_next = 1'b0;
                            sp = 1'b1;
                        end
                        else if (press_reg > cfg.long_press_limit)
                        begin
                            er = 1'b1;
                            reboot_next = 7'd1;
                        end
                    end
                    press_next = '0;
                end
            end
            OP_LINK:
                link_next = held.link_value;
            OP_ATOM:
                atom_next = power_reg && held.enable;
            default: ;
        endcase
    end

    // State registers, updated as the beat moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= LINK_PAIRING;
            blink_reg <= '0;
            hold_reg <= '0;
            press_reg <= '0;
            reboot_reg <= '0;
            red_reg <= 1'b0;
            power_reg <= 1'b0;
            atom_reg <= 1'b0;
            phase_reg <= 1'b0;
            fired_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            link_reg <= link_next;
            blink_reg <= blink_next;
            hold_reg <= hold_next;
            press_reg <= press_next;
            reboot_reg <= reboot_next;
            red_reg <= red_next;
            power_reg <= power_next;
            atom_reg <= atom_next;
            phase_reg <= phase_next;
            fired_reg <= fired_next;
        end
    end

    assign res.red_led = red_next;
    assign res.atomizer_on = atom_next;
    assign res.power_on = power_next;
    assign res.short_press = sp;
    assign res.erase_request = er;
    assign res.reboot_request = fired_next;
    assign res.link_now = link_next;

endmodule

@@ rtl/core/bpsl_out_stage.sv @@
module bpsl_out_stage
    import bpsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_ctl_t ctl,
    input  result_t    res,
    output logic       out_free,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Free when empty or when the waiting beat goes this cycle
    assign out_free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.advance)
            valid_next = 1'b1;
        else if (!result_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
            data_reg <= res;
    end

    assign result_valid = valid_reg;
    assign result = data_reg;

endmodule

@@ rtl/core/button_press_and_status_led_controller.sv @@
// Channel    Direction  Handshake                    Payload
// item       in         item_valid / item_stall      item   (item_t)
// result     out        result_valid / result_stall  result (result_t)
// cfg        in         cfg_we                       cfg_index, cfg_data
//
// One beat per cycle sustained while result_stall stays low; each item gives one
// result, registered in the input register, then in the result register.
// Rate is set by the single state update between the two registers.
// rst_n clears all state and loads the default configuration.
// A stalled result holds the result register; the input register then fills
// and item_stall rises until the result moves.
module button_press_and_status_led_controller
    import bpsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    stage_ctl_t ctl;
    item_t      held;
    result_t    res;
    logic       out_free;

    bpsl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpsl_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .out_free   (out_free),
        .ctl        (ctl),
        .held       (held)
    );

    bpsl_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .ctl   (ctl),
        .held  (held),
        .res   (res)
    );

    bpsl_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .res          (res),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Checks

    // Stall only with a beat held in the input register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> ctl.valid)
        else $error("item stall without a held beat");

    // Short and long press never reported together
    a_press_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.short_press && result.erase_request))
        else $error("short and long press in one result");

    // Atomizer only runs with power on
    a_atom_power: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.atomizer_on || result.power_on))
        else $error("atomizer on with power off");

    // Reboot request latches until reset
    a_reboot_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.advance && res.reboot_request) |=> res.reboot_request)
        else $error("reboot request dropped");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import bpsl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shared run state
    bit          failed = 1'b0;
    bit          steady = 1'b0;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    result_t     expected_status[$];

    // Own copy of the controller state
    logic [1:0]  link_st = LINK_PAIRING;
    logic [7:0]  blink_cnt = '0;
    logic [8:0]  hold_cnt = '0;
    logic [15:0] press_len = '0;
    logic [6:0]  reboot_cnt = '0;
    logic        red_lvl = 1'b0;
    logic        power_lvl = 1'b0;
    logic        atom_lvl = 1'b0;
    logic        blink_lvl = 1'b0;
    logic        reboot_latched = 1'b0;

    // Own copy of the register file
    logic [15:0] lim_short = RST_SHORT_LIMIT;
    logic [15:0] lim_long = RST_LONG_LIMIT;
    logic [7:0]  div_blink = RST_BLINK_DIV;
    logic [7:0]  hold_lim = RST_GOT_IP_HOLD;
    logic [5:0]  delay_reboot = RST_REBOOT_DELAY;

    button_press_and_status_led_controller u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Status the controller should show after one accepted beat
    function automatic result_t predict_status(input item_t it);
        result_t r;
        logic    sp;
        logic    er;
        sp = 1'b0;
        er = 1'b0;
        case (it.op)
            OP_TICK:
            begin
                // LED pattern for the current link state
                case (link_st)
                    LINK_PAIRING:
                    begin
                        blink_cnt = blink_cnt + 8'd1;
                        if (blink_cnt >= div_blink)
                        begin
                            blink_cnt = '0;
                            blink_lvl = ~blink_lvl;
                            red_lvl = blink_lvl;
                        end
                    end
                    LINK_NO_ADDR:
                        red_lvl = 1'b0;
                    LINK_GOT_ADDR:
                    begin
                        if (hold_cnt == '0)
                        begin
                            red_lvl = 1'b1;
                            hold_cnt = 9'd1;
                        end
                        else if (hold_cnt > {1'b0, hold_lim})
                        begin
                            hold_cnt = '0;
                            red_lvl = 1'b0;
                            link_st = LINK_IDLE;
                        end
                        else
                            hold_cnt = hold_cnt + 9'd1;
                    end
                    default: ;
                endcase
                // button: ignored for good once a reboot countdown runs
                if (reboot_cnt != '0)
                begin
                    if (reboot_cnt < REBOOT_MAX)
                        reboot_cnt = reboot_cnt + 7'd1;
                    if (reboot_cnt > {1'b0, delay_reboot})
                        reboot_latched = 1'b1;
                end
                else if (!it.key_level)
                begin
                    if (press_len < PRESS_MAX)
                        press_len = press_len + 16'd1;
                end
                else
                begin
                    if (press_len != '0)
                    begin
                        if (press_len < lim_short)
                        begin
                            power_lvl = ~power_lvl;
                            atom_lvl = 1'b0;
                            sp = 1'b1;
                        end
                        else if (press_len > lim_long)
                        begin
                            er = 1'b1;
                            reboot_cnt = 7'd1;
                        end
                    end
                    press_len = '0;
                end
            end
            OP_LINK:
                link_st = it.link_value;
            OP_ATOM:
                atom_lvl = power_lvl ? it.enable : 1'b0;
            default: ;
        endcase
        r.red_led = red_lvl;
        r.atomizer_on = atom_lvl;
        r.power_on = power_lvl;
        r.short_press = sp;
        r.erase_request = er;
        r.reboot_request = reboot_latched;
        r.link_now = link_st;
        return r;
    endfunction

    task automatic compare_status(input result_t exp_r, input result_t got_r);
        if (got_r.red_led !== exp_r.red_led)
        begin
            $error("red_led: expected %0d, got %0d", exp_r.red_led, got_r.red_led);
            failed = 1'b1;
        end
        if (got_r.atomizer_on !== exp_r.atomizer_on)
        begin
            $error("atomizer_on: expected %0d, got %0d", exp_r.atomizer_on, got_r.atomizer_on);
            failed = 1'b1;
        end
        if (got_r.power_on !== exp_r.power_on)
        begin
            $error("power_on: expected %0d, got %0d", exp_r.power_on, got_r.power_on);
            failed = 1'b1;
        end
        if (got_r.short_press !== exp_r.short_press)
        begin
            $error("short_press: expected %0d, got %0d", exp_r.short_press, got_r.short_press);
            failed = 1'b1;
        end
        if (got_r.erase_request !== exp_r.erase_request)
        begin
            $error("erase_request: expected %0d, got %0d",
                   exp_r.erase_request, got_r.erase_request);
            failed = 1'b1;
        end
        if (got_r.reboot_request !== exp_r.reboot_request)
        begin
            $error("reboot_request: expected %0d, got %0d",
                   exp_r.reboot_request, got_r.reboot_request);
            failed = 1'b1;
        end
        if (got_r.link_now !== exp_r.link_now)
        begin
            $error("link_now: expected %0d, got %0d", exp_r.link_now, got_r.link_now);
            failed = 1'b1;
        end
    endtask

    // Result side: check each beat, stall at random
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_status.size() == 0)
            begin
                $error("result beat with no expected status pending");
                failed = 1'b1;
            end
            else
                compare_status(expected_status.pop_front(), result);
        end
        result_stall <= !steady && ($urandom_range(99) < 15);
    end

    // One item beat; valid stays high on return
    task automatic send_item(input item_t it);
        if (!steady && $urandom_range(99) < 15)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
        expected_status.push_back(predict_status(it));
        items_sent++;
    endtask

    // Random don't-care fields, given opcode
    function automatic item_t rand_item(input logic [1:0] op);
        logic [31:0] r;
        item_t       it;
        r = $urandom;
        it = r[$bits(item_t)-1:0];
        it.op = op;
        return it;
    endfunction

    task automatic send_tick(input logic key);
        item_t it;
        it = rand_item(OP_TICK);
        it.key_level = key;
        send_item(it);
    endtask

    task automatic send_link(input logic [1:0] v);
        item_t it;
        it = rand_item(OP_LINK);
        it.link_value = v;
        send_item(it);
    endtask

    task automatic send_atom(input logic en);
        item_t it;
        it = rand_item(OP_ATOM);
        it.enable = en;
        send_item(it);
    endtask

    // Any non-tick item
    task automatic send_other();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            send_item(rand_item(OP_LINK));
        else if (pick < 85)
            send_item(rand_item(OP_ATOM));
        else
            send_item(rand_item(OP_NONE));
    endtask

    // Drop valid and wait until every status beat is back
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SHORT_LIMIT:  lim_short = val;
            CFG_LONG_LIMIT:   lim_long = val;
            CFG_BLINK_DIV:    div_blink = val[7:0];
            CFG_GOT_IP_HOLD:  hold_lim = val[7:0];
            CFG_REBOOT_DELAY: delay_reboot = val[5:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Full register set; junk above the narrow registers' widths
    task automatic apply_config(input logic [15:0] s_lim, input logic [15:0] l_lim,
                                input logic [7:0] div, input logic [7:0] hold,
                                input logic [5:0] delay);
        logic [15:0] junk;
        junk = $urandom;
        wait_drained();
        write_reg(CFG_SHORT_LIMIT, s_lim);
        write_reg(CFG_LONG_LIMIT, l_lim);
        write_reg(CFG_BLINK_DIV, {junk[15:8], div});
        write_reg(CFG_GOT_IP_HOLD, {junk[7:0], hold});
        write_reg(CFG_REBOOT_DELAY, {junk[9:0], delay});
    endtask

    // Press no longer than the long limit, then release
    task automatic random_press();
        int unsigned top;
        int unsigned n;
        top = (lim_long > 80) ? 80 : lim_long;
        if ($urandom_range(99) < 70 && top > lim_short + 5)
            top = lim_short + 5;
        if (top < 1)
            top = 1;
        n = $urandom_range(top, 1);
        repeat (n)
        begin
            if ($urandom_range(99) < 10)
                send_other();
            send_tick(1'b0);
        end
        send_tick(1'b1);
    endtask

    task automatic test_reset_state();
        logic [CFG_IDX_W-1:0] idx;
        send_item(rand_item(OP_NONE));
        send_tick(1'b1);
        // unmapped indexes must change nothing
        wait_drained();
        for (idx = CFG_REBOOT_DELAY + 3'd1; idx != '0; idx++)
            write_reg(idx, CFG_DATA_W'($urandom));
        send_tick(1'b1);
    endtask

    task automatic test_power_and_atomizer();
        apply_config(16'd3, 16'd6, 8'd1, 8'd0, 6'd20);
        send_tick(1'b1);
        // atomizer request with power off stays off
        send_atom(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_atom(1'b1);
        send_atom(1'b0);
        send_atom(1'b1);
        // press between the limits: no action
        repeat (4) send_tick(1'b0);
        send_tick(1'b1);
        // second short press: power off, atomizer stopped
        send_tick(1'b0);
        send_tick(1'b1);
        send_atom(1'b1);
        send_item(rand_item(OP_NONE));
    endtask

    task automatic test_link_led();
        send_link(LINK_NO_ADDR);
        send_tick(1'b1);
        send_link(LINK_GOT_ADDR);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_link(LINK_IDLE);
        send_tick(1'b1);
        send_link(LINK_PAIRING);
    endtask

    task automatic test_blink_divider();
        // zero divider toggles every tick
        wait_drained();
        write_reg(CFG_BLINK_DIV, 16'd0);
        repeat (2) send_tick(1'b1);
        wait_drained();
        write_reg(CFG_BLINK_DIV, 16'd255);
        repeat (5) send_tick(1'b1);
        // divider lowered below the running count
        wait_drained();
        write_reg(CFG_BLINK_DIV, 16'd2);
        repeat (2) send_tick(1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned start;
        int unsigned pick;
        logic [15:0] s_lim;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: apply_config(16'd1, 16'hFFFF, 8'd1, 8'd0, 6'd0);
                1: apply_config(16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 6'd63);
                5: apply_config(16'($urandom_range(3, 1)), 16'd1, 8'($urandom_range(8, 1)),
                                8'($urandom_range(10)), 6'($urandom_range(63)));
                default:
                begin
                    s_lim = 16'($urandom_range(30, 2));
                    apply_config(s_lim, s_lim + 16'($urandom_range(40)),
                                 8'($urandom_range(20, 1)), 8'($urandom_range(40)),
                                 6'($urandom_range(63)));
                end
            endcase
            // one phase without random idle gaps or random stalls on either side
            steady = (phase == 2);
            start = items_sent;
            while (items_sent - start < 170)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    random_press();
                else if (pick < 65)
                    repeat ($urandom_range(5, 1)) send_tick(1'b1);
                else if (pick < 97)
                    send_other();
                else
                    wait_drained();
            end
            steady = 1'b0;
        end
    endtask

    // Presses just under and at the short limit, and at the long limit
    task automatic test_press_limits();
        apply_config(16'd5, 16'd9, 8'd7, 8'd20, 6'd10);
        // just under the short limit: short press
        repeat (4) send_tick(1'b0);
        send_tick(1'b1);
        // equal to the short limit: no action
        repeat (5) send_tick(1'b0);
        send_tick(1'b1);
        // equal to the long limit: no action
        repeat (9) send_tick(1'b0);
        send_tick(1'b1);
        // release with no press running
        send_tick(1'b1);
    endtask

    // Long press: erase pulse, then countdown to a latched reboot request
    task automatic test_long_press_reboot();
        apply_config(16'd1, 16'd1, 8'd3, 8'd2, 6'd63);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        repeat (250)
        begin
            if ($urandom_range(99) < 80)
                send_tick(1'($urandom));
            else
                send_other();
        end
        wait_drained();
        write_reg(CFG_REBOOT_DELAY, 16'd0);
        repeat (10) send_tick(1'($urandom));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_power_and_atomizer();
        test_link_led();
        test_blink_divider();
        test_random_traffic();
        test_press_limits();
        test_long_press_reboot();
        wait_drained();
        repeat (8) @(posedge clk);
        if (!failed && expected_status.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
